// ===== rtl/core/olad_pkg.sv =====
// Package with the request and result types and the sequencer states of the ordered list.
`timescale 1ns / 1ps
package olad_pkg;

  localparam int unsigned ValueW     = 32;
  localparam int unsigned PosW       = 4;
  localparam int unsigned MaxResults = 16;

  localparam logic OpAppend = 1'b0;
  localparam logic OpDelete = 1'b1;

  typedef struct packed {
    logic                     op;
    logic signed [ValueW-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [ValueW-1:0] element;
    logic        [PosW-1:0]   position;
    logic                     is_last;
  } res_t;

  typedef enum logic [2:0] {
    StIdle,
    StSearchRd,
    StSearchCmp,
    StShiftRd,
    StShiftWr,
    StList
  } state_e;

endpackage

// ===== rtl/core/ordered_list_append_delete.sv =====
// Top level of the ordered list with append at the tail and delete of the first match.
`timescale 1ns / 1ps
// The block keeps an ordered list of signed 32-bit values in a store of CAPACITY words.
// A request transfer happens at a rising edge with start high and busy low. An append
// (op 0) writes its value behind the tail unless the list is full; a delete (op 1)
// searches from the head for the first equal entry and moves every entry behind it up
// one place. After each request the whole list is sent from head to tail, one result
// transfer per entry, each on res_o for exactly one cycle marked by res_valid_o, with
// is_last set on the last entry sent. An empty list sends nothing. Only the first sixteen
// entries are listed when CAPACITY is larger.
// All work goes through one single-port-read store and one comparator and incrementer
// under a small sequencer. An append writes its entry and then lists. A delete reads and
// compares each entry searched, reads and writes each entry moved, closes the move and
// then lists the entries. The last result is shown in the first cycle with busy low, so
// a new request can overlap it. Reset empties the list and returns the sequencer to idle;
// the store itself is not cleared, since only written entries are ever read. The
// receiver cannot stall, so results are never held back.
module ordered_list_append_delete #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  olad_pkg::req_t   req_i,
  output logic             res_valid_o,
  output olad_pkg::res_t   res_o
);
  import olad_pkg::*;

  localparam int unsigned AW      = $clog2(CAPACITY);
  localparam int unsigned LW      = $clog2(CAPACITY + 1);
  localparam int unsigned ListMax = (CAPACITY < MaxResults) ? CAPACITY : MaxResults;

  state_e state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] idx_q, idx_d;
  logic [ValueW-1:0] val_q, val_d;

  // Store and its registered read port.
  logic [ValueW-1:0] mem [CAPACITY];
  logic              we;
  logic [AW-1:0]     waddr;
  logic [ValueW-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [ValueW-1:0] rdata_q;

  // Result register.
  logic            emit_q, emit_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            last_q, last_d;

  // Shared compare and increment unit.
  logic [LW-1:0] idx_inc;
  logic          idx_at_end;
  logic          hit;
  logic [LW-1:0] count;
  logic          accept;

  assign idx_inc    = idx_q + LW'(1);
  assign idx_at_end = (idx_inc == len_q);
  assign hit        = (rdata_q == val_q);
  assign count      = (len_q > LW'(ListMax)) ? LW'(ListMax) : len_q;
  assign accept     = start && !busy;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (req_i.op == OpAppend) begin
            state_d = StList;
          end else if (len_q != '0) begin
            state_d = StSearchRd;
          end
        end
      end
      StSearchRd: begin
        state_d = StSearchCmp;
      end
      StSearchCmp: begin
        if (hit) begin
          state_d = StShiftRd;
        end else if (idx_at_end) begin
          state_d = StList;
        end else begin
          state_d = StSearchRd;
        end
      end
      StShiftRd: begin
        if (idx_inc < len_q) begin
          state_d = StShiftWr;
        end else if (len_q == LW'(1)) begin
          state_d = StIdle;
        end else begin
          state_d = StList;
        end
      end
      StShiftWr: begin
        state_d = StShiftRd;
      end
      StList: begin
        if (idx_inc >= count) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath control.
  always_comb begin
    len_d  = len_q;
    idx_d  = idx_q;
    val_d  = val_q;
    we     = 1'b0;
    waddr  = idx_q[AW-1:0];
    wdata  = rdata_q;
    re     = 1'b0;
    raddr  = idx_q[AW-1:0];
    emit_d = 1'b0;
    pos_d  = pos_q;
    last_d = last_q;
    unique case (state_q)
      StIdle: begin
        idx_d = '0;
        if (accept) begin
          val_d = req_i.value;
          if ((req_i.op == OpAppend) && (len_q < LW'(CAPACITY))) begin
            we    = 1'b1;
            waddr = len_q[AW-1:0];
            wdata = req_i.value;
            len_d = len_q + LW'(1);
          end
        end
      end
      StSearchRd: begin
        re = 1'b1;
      end
      StSearchCmp: begin
        if (!hit) begin
          idx_d = idx_at_end ? '0 : idx_inc;
        end
      end
      StShiftRd: begin
        if (idx_inc < len_q) begin
          re    = 1'b1;
          raddr = idx_inc[AW-1:0];
        end else begin
          len_d = len_q - LW'(1);
          idx_d = '0;
        end
      end
      StShiftWr: begin
        we    = 1'b1;
        idx_d = idx_inc;
      end
      StList: begin
        re     = 1'b1;
        emit_d = 1'b1;
        pos_d  = PosW'(idx_q);
        last_d = (idx_inc == count);
        idx_d  = idx_inc;
      end
      default: begin
        idx_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      len_q   <= '0;
      idx_q   <= '0;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      emit_q  <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    pos_q  <= pos_d;
    last_q <= last_d;
  end

  assign busy           = (state_q != StIdle);
  assign res_valid_o    = emit_q;
  assign res_o.element  = rdata_q;
  assign res_o.position = pos_q;
  assign res_o.is_last  = last_q;

  // The fill count never passes the store size.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(CAPACITY))
    else $error("list length beyond capacity");

  // A result that is not marked last is followed at once by the next position.
  a_list_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.is_last) |=>
      (res_valid_o && (res_o.position == PosW'($past(res_o.position) + 1'b1))))
    else $error("listing broken before the tail");

  // While the listing is unfinished, no new request can be taken.
  a_busy_mid_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.is_last) |-> busy)
    else $error("idle in the middle of a listing");

  // An append always leaves a non-empty list to send.
  a_append_lists: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.op == OpAppend)) |=> (busy && (len_q != '0)))
    else $error("append did not start a listing");

endmodule
